// File: rtl/crde_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crde_pkg - shared definitions for the command record delta encoder
// Field codes, record geometry, the baseline update bundle and the
// per-field width lookup.
// ---------------------------------------------------------------------------
package crde_pkg;

  localparam int FIELD_COUNT = 14;
  localparam int IDX_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 6;
  localparam int CHUNK_W     = VALUE_W + 1;

  // field codes
  localparam logic [IDX_W-1:0] FLD_SEQ     = 4'd0;
  localparam logic [IDX_W-1:0] FLD_TICK    = 4'd1;
  localparam logic [IDX_W-1:0] FLD_IMPULSE = 4'd9;
  localparam logic [IDX_W-1:0] FLD_WEAPON  = 4'd10;
  localparam logic [IDX_W-1:0] FLD_SUBTYPE = 4'd11;
  localparam logic [IDX_W-1:0] FLD_MOUSE_X = 4'd12;
  localparam logic [IDX_W-1:0] FLD_MOUSE_Y = 4'd13;

  localparam logic [LEN_W-1:0] WIDTH_FULL    = 6'd32;
  localparam logic [LEN_W-1:0] WIDTH_IMPULSE = 6'd8;
  localparam logic [LEN_W-1:0] WIDTH_MOUSE   = 6'd16;
  localparam logic [LEN_W-1:0] LEN_FLAG_ONLY = 6'd1;

  // write into the stored previous record
  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       idx;
    logic [VALUE_W-1:0]     value;
    logic                   weapon_we;
    logic                   weapon_changed;
  } crde_update_t;

  function automatic logic [LEN_W-1:0] field_width(
    input logic [IDX_W-1:0] idx,
    input logic [LEN_W-1:0] weapon_w,
    input logic [LEN_W-1:0] subtype_w
  );
    logic [LEN_W-1:0] w;
    case (idx)
      FLD_IMPULSE: w = WIDTH_IMPULSE;
      FLD_WEAPON:  w = weapon_w;
      FLD_SUBTYPE: w = subtype_w;
      FLD_MOUSE_X: w = WIDTH_MOUSE;
      FLD_MOUSE_Y: w = WIDTH_MOUSE;
      default:     w = WIDTH_FULL;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/command_record_delta_encoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// command_record_delta_encoder - field-wise delta encoder
// Streams record fields in, streams flag/value bit chunks out.
// ---------------------------------------------------------------------------
// One field enters per transaction (s_tuser picks the field, s_tdata holds
// its raw bits, s_tlast marks the last field of a record). Each field is
// cut to its width and compared against the same field of the previous
// record; the chunk is a single 0 bit if unchanged, else a 1 followed by the
// value LSB first (seq and tick count as unchanged when they advance by
// one). A subtype field gives no chunk unless the weapon field changed;
// codes above 13 are dropped. Throughput is one field per clock unless a
// chunk stalls on m_tready: the input register, one compare against the
// stored field and the output register form a two-stage pipeline; m_tvalid
// comes from the output register. While a chunk waits on m_tready the input
// register can still take one more field; after that s_tready drops until
// the chunk leaves. The stored record resets to zero.
// ---------------------------------------------------------------------------
module command_record_delta_encoder
  import crde_pkg::*;
#(
  parameter int ENTITY_INDEX_BITS = 11,
  parameter int SUBTYPE_BITS      = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] field_value
  input  wire logic [3:0]  s_tuser,   // [3:0] field_index
  input  wire logic        s_tlast,   // record_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [32:0] chunk_bits, [38:33] chunk_length, [39] zero
  output logic             m_tlast    // chunk_last
);

  // field widths clamped to 1..32
  localparam int WEAPON_W  = (ENTITY_INDEX_BITS < 1) ? 1 :
                             (ENTITY_INDEX_BITS > 32) ? 32 : ENTITY_INDEX_BITS;
  localparam int SUBTYPE_W = (SUBTYPE_BITS < 1) ? 1 :
                             (SUBTYPE_BITS > 32) ? 32 : SUBTYPE_BITS;

  // input stage
  logic               in_valid;
  logic [IDX_W-1:0]   in_idx;
  logic [VALUE_W-1:0] in_value;
  logic               in_last;

  // encode results
  logic               advance;
  logic               emit;
  logic [CHUNK_W-1:0] enc_bits;
  logic [LEN_W-1:0]   enc_length;
  logic [VALUE_W-1:0] prev_value;
  logic               weapon_changed;
  crde_update_t       upd;

  // output stage
  logic [CHUNK_W-1:0] out_bits;
  logic [LEN_W-1:0]   out_length;

  // the held field moves on once the output register can take its chunk
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_idx   <= s_tuser;
      in_value <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  crde_baseline u_baseline (
    .clk            (clk),
    .rst            (rst),
    .rd_idx         (in_idx),
    .rd_value       (prev_value),
    .weapon_changed (weapon_changed),
    .upd            (upd)
  );

  crde_encode #(
    .WEAPON_W  (WEAPON_W),
    .SUBTYPE_W (SUBTYPE_W)
  ) u_encode (
    .fire           (advance),
    .idx            (in_idx),
    .raw            (in_value),
    .prev           (prev_value),
    .weapon_changed (weapon_changed),
    .emit           (emit),
    .chunk_bits     (enc_bits),
    .chunk_length   (enc_length),
    .upd            (upd)
  );

  // output register; fields that give no chunk only touch the baseline
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_bits   <= enc_bits;
      out_length <= enc_length;
      m_tlast    <= in_last;
    end
  end

  assign m_tdata = {1'b0, out_length, out_bits};

endmodule
`default_nettype wire

// File: rtl/crde_baseline.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crde_baseline - previous record store
// Holds the last value of each field and the weapon-changed flag.
// ---------------------------------------------------------------------------
module crde_baseline
  import crde_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [IDX_W-1:0]   rd_idx,
  output logic      [VALUE_W-1:0] rd_value,
  output logic                    weapon_changed,
  input  wire crde_update_t       upd
);

  logic [VALUE_W-1:0] prev [FIELD_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        prev[i] <= '0;
      end
      weapon_changed <= 1'b0;
    end else begin
      if (upd.we && (upd.idx < IDX_W'(FIELD_COUNT))) begin
        prev[upd.idx] <= upd.value;
      end
      if (upd.weapon_we) begin
        weapon_changed <= upd.weapon_changed;
      end
    end
  end

  // out-of-range codes read as zero; the encoder drops them anyway
  assign rd_value = (rd_idx < IDX_W'(FIELD_COUNT)) ? prev[rd_idx] : '0;

endmodule
`default_nettype wire

// File: rtl/crde_encode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crde_encode - field compare and chunk pack
// Masks the field to its width, compares it with the baseline and builds
// the flag/value chunk plus the baseline update.
// ---------------------------------------------------------------------------
module crde_encode
  import crde_pkg::*;
#(
  parameter int WEAPON_W  = 11,
  parameter int SUBTYPE_W = 6
) (
  input  wire logic               fire,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire logic [VALUE_W-1:0] raw,
  input  wire logic [VALUE_W-1:0] prev,
  input  wire logic               weapon_changed,
  output logic                    emit,
  output logic      [CHUNK_W-1:0] chunk_bits,
  output logic      [LEN_W-1:0]   chunk_length,
  output crde_update_t            upd
);

  logic [LEN_W-1:0]   w;
  logic [CHUNK_W-1:0] ones;
  logic [VALUE_W-1:0] val;
  logic               valid_idx;
  logic               changed;

  always_comb begin
    w         = field_width(idx, LEN_W'(WEAPON_W), LEN_W'(SUBTYPE_W));
    ones      = (CHUNK_W'(1) << w) - CHUNK_W'(1);
    val       = raw & ones[VALUE_W-1:0];
    valid_idx = idx < IDX_W'(FIELD_COUNT);

    // seq and tick are expected to advance by one
    if (idx == FLD_SEQ || idx == FLD_TICK) begin
      changed = val != (prev + VALUE_W'(1));
    end else begin
      changed = val != prev;
    end

    // subtype is only sent alongside a weapon switch
    emit = valid_idx && !(idx == FLD_SUBTYPE && !weapon_changed);

    if (changed) begin
      chunk_bits   = {val, 1'b1};
      chunk_length = LEN_FLAG_ONLY + w;
    end else begin
      chunk_bits   = '0;
      chunk_length = LEN_FLAG_ONLY;
    end

    upd.we             = fire && valid_idx;
    upd.idx            = idx;
    upd.value          = val;
    upd.weapon_we      = fire && (idx == FLD_WEAPON);
    upd.weapon_changed = changed;
  end

endmodule
`default_nettype wire

// File: rtl/crde_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// crde_checker - port-level checks for the delta encoder
// Watches the output stream for chunk format and handshake rules.
// ---------------------------------------------------------------------------
module crde_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // a stalled chunk holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled chunk changed");

  // output stream is empty right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("chunk present after reset");

  // unchanged field: lone zero flag
  a_flag_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[38:33] == 6'd1 && m_tdata[32:1] == 32'd0)
    else $error("unchanged chunk carries payload");

  // changed field: length covers flag plus 1..32 value bits
  a_changed_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[38:33] >= 6'd2 && m_tdata[38:33] <= 6'd33)
    else $error("changed chunk length out of range");

endmodule

bind command_record_delta_encoder crde_checker u_crde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: bench/command_record_delta_encoder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// command_record_delta_encoder_tb - self-checking bench for the delta encoder
// Feeds command records field by field through the input stream, predicts
// each flag/value chunk from its own copy of the previous record and checks
// every chunk on the output stream. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module command_record_delta_encoder_tb;
  import crde_pkg::*;

  localparam int ENTITY_INDEX_BITS = 11;
  localparam int SUBTYPE_BITS      = 6;

  // field widths as the block clamps them (0 -> 1, above 32 -> 32)
  localparam int WEAPON_W  = (ENTITY_INDEX_BITS < 1) ? 1 :
                             (ENTITY_INDEX_BITS > 32) ? 32 : ENTITY_INDEX_BITS;
  localparam int SUBTYPE_W = (SUBTYPE_BITS < 1) ? 1 :
                             (SUBTYPE_BITS > 32) ? 32 : SUBTYPE_BITS;

  localparam int FIELD_TARGET = 1800;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;  // two-stage pipe plus margin

  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               last;
  } chunk_t;

  // -------------------------------------------------------------------------
  // Predictor: keeps the previous record and the queue of chunks still owed.
  // -------------------------------------------------------------------------
  class delta_chunk_predictor;
    logic [VALUE_W-1:0] baseline [FIELD_COUNT];
    logic               weapon_moved;
    chunk_t             expected_chunks [$];
    int                 mismatches;
    int                 checked;

    function new();
      foreach (baseline[i]) baseline[i] = '0;
      weapon_moved = 1'b0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function int width_of(int idx);
      case (idx)
        FLD_IMPULSE: return 8;
        FLD_WEAPON:  return WEAPON_W;
        FLD_SUBTYPE: return SUBTYPE_W;
        FLD_MOUSE_X,
        FLD_MOUSE_Y: return 16;
        default:     return 32;
      endcase
    endfunction

    function logic [VALUE_W-1:0] mask_of(int w);
      return VALUE_W'((64'd1 << w) - 64'd1);
    endfunction

    // accepted input transaction -> at most one owed chunk
    function void note_field(logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] raw,
                             logic last);
      int                 w;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] prev;
      logic               changed;
      chunk_t             c;
      if (idx >= FIELD_COUNT) return;  // unknown code: dropped, state untouched
      w    = width_of(idx);
      v    = raw & mask_of(w);
      prev = baseline[idx];
      // seq and tick are expected to advance by one
      if (idx == FLD_SEQ || idx == FLD_TICK) changed = (v != prev + 32'd1);
      else changed = (v != prev);
      baseline[idx] = v;
      if (idx == FLD_WEAPON) weapon_moved = changed;
      // subtype only travels with a new weapon; its baseline moves anyway
      if (idx == FLD_SUBTYPE && !weapon_moved) return;
      if (changed) begin
        c.bits = {v, 1'b1};
        c.len  = LEN_W'(w + 1);
      end else begin
        c.bits = '0;
        c.len  = LEN_FLAG_ONLY;
      end
      c.last = last;
      expected_chunks.push_back(c);
    endfunction

    // accepted output transaction vs oldest owed chunk
    function void check_chunk(chunk_t got);
      chunk_t want;
      if (expected_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: chunk with none owed: bits %h len %0d last %b",
                   $realtime, got.bits, got.len, got.last);
        return;
      end
      want = expected_chunks.pop_front();
      checked++;
      if (got.bits !== want.bits || got.len !== want.len || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: chunk %0d: bits %h/%h len %0d/%0d last %b/%b (exp/act)",
                   $realtime, checked, want.bits, got.bits, want.len, got.len,
                   want.last, got.last);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and clock
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] field_value
  logic [3:0]  s_tuser;   // [3:0] field_index
  logic        s_tlast;   // record_end
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [32:0] chunk_bits, [38:33] chunk_length, [39] zero
  logic        m_tlast;   // chunk_last

  command_record_delta_encoder #(
    .ENTITY_INDEX_BITS(ENTITY_INDEX_BITS),
    .SUBTYPE_BITS     (SUBTYPE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  delta_chunk_predictor predictor = new();

  // generator's view of the last sent value of each field, cut to width
  logic [VALUE_W-1:0] sent_record [FIELD_COUNT];
  int fields_sent;
  int ignored_sent;
  int records_sent;
  int src_calm;
  int snk_calm;

  // A random idle gap before each transaction, with occasional calm stretches
  // where the side never idles.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // One input transaction. Drive on the falling edge, wait for acceptance
  // seen at a rising edge.
  task automatic send_field(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] val,
                            input logic last);
    int gap;
    gap = draw_wait(src_calm);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = idx;
    s_tdata  = val;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    predictor.note_field(idx, val, last);
    if (idx < FIELD_COUNT) begin
      sent_record[idx] = val & predictor.mask_of(predictor.width_of(idx));
      fields_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  // Mostly whole records in field order with a few fields changing; now and
  // then a cut-short record, a skipped field or a burst of stray fields.
  task automatic send_record();
    int                 cut;
    int                 i;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] m;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_field(IDX_W'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
      return;
    end
    cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, FIELD_COUNT - 2)
                                       : FIELD_COUNT - 1;
    for (i = 0; i <= cut; i++) begin
      if (i != cut && $urandom_range(0, 29) == 0) continue;
      m = predictor.mask_of(predictor.width_of(i));
      if (i == FLD_SEQ || i == FLD_TICK) begin
        v = ($urandom_range(0, 4) != 0) ? sent_record[i] + 32'd1 : $urandom;
      end else if (i == FLD_WEAPON) begin
        v = ($urandom_range(0, 1) != 0) ? sent_record[i] : $urandom;
      end else if ($urandom_range(0, 4) < 3) begin
        v = sent_record[i];
      end else begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          default: v = $urandom;
        endcase
      end
      // junk above the field width must not matter
      if ($urandom_range(0, 3) == 0) v = v | ($urandom & ~m);
      send_field(IDX_W'(i), v, i == cut);
    end
    records_sent++;
  endtask

  // -------------------------------------------------------------------------
  // Output side: random stalls, check every accepted chunk
  // -------------------------------------------------------------------------
  initial begin
    int     stall;
    chunk_t got;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(snk_calm);
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.bits = m_tdata[CHUNK_W-1:0];
      got.len  = m_tdata[CHUNK_W+LEN_W-1:CHUNK_W];
      got.last = m_tlast;
      predictor.check_chunk(got);
    end
  end

  // -------------------------------------------------------------------------
  // Input side: reset, directed fields, then random records
  // -------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    s_tlast      = 1'b0;
    fields_sent  = 0;
    ignored_sent = 0;
    records_sent = 0;
    src_calm     = 0;
    snk_calm     = 0;
    foreach (sent_record[i]) sent_record[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // seq one past the zero baseline: unchanged; tick all ones: changed
    send_field(FLD_SEQ, 32'h0000_0001, 1'b0);
    send_field(FLD_TICK, 32'hFFFF_FFFF, 1'b0);
    // negative zero and a NaN pattern compare as raw bits
    send_field(IDX_W'(2), 32'h8000_0000, 1'b0);
    send_field(IDX_W'(3), 32'h7FC0_0000, 1'b0);
    send_field(IDX_W'(4), 32'hFFFF_FFFF, 1'b0);
    send_field(IDX_W'(5), 32'hFFFF_FFFF, 1'b0);
    send_field(IDX_W'(6), 32'h0000_0000, 1'b0);
    send_field(IDX_W'(8), 32'hA5A5_5A5A, 1'b0);
    // impulse with only bits above its width set: cut to zero, unchanged
    send_field(FLD_IMPULSE, 32'hFFFF_FF00, 1'b0);
    // new weapon, so the subtype is coded
    send_field(FLD_WEAPON, 32'hFFFF_FFFF, 1'b0);
    send_field(FLD_SUBTYPE, 32'hFFFF_FFFF, 1'b0);
    send_field(FLD_MOUSE_X, 32'hABCD_1234, 1'b0);
    send_field(FLD_MOUSE_Y, 32'h0000_FFFF, 1'b1);
    // same weapon under junk high bits; subtype then drops, with its record end
    send_field(FLD_WEAPON, 32'h5555_57FF, 1'b0);
    send_field(FLD_SUBTYPE, 32'h0000_0001, 1'b1);
    // codes past the record are dropped
    send_field(IDX_W'(FIELD_COUNT), 32'hFFFF_FFFF, 1'b0);
    send_field(IDX_W'(15), 32'h1234_5678, 1'b1);
    // seq advancing, seq repeated, tick wrapping to zero
    send_field(FLD_SEQ, 32'h0000_0002, 1'b0);
    send_field(FLD_SEQ, 32'h0000_0002, 1'b0);
    send_field(FLD_TICK, 32'h0000_0000, 1'b0);
    // weapon back to zero, subtype changes again
    send_field(FLD_WEAPON, 32'h0000_0000, 1'b0);
    send_field(FLD_SUBTYPE, 32'h0000_0000, 1'b0);
    send_field(IDX_W'(7), 32'h0000_0001, 1'b1);

    while (fields_sent < FIELD_TARGET) send_record();

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    // drain, then give any stray chunk time to show up
    while (predictor.expected_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d record fields (%0d record runs) and %0d out-of-range codes;",
             fields_sent, records_sent, ignored_sent);
    $display("checked %0d chunks, %0d mismatches.", predictor.checked,
             predictor.mismatches);
    if (predictor.mismatches == 0 && predictor.expected_chunks.size() == 0) begin
      $display("[command_record_delta_encoder] OK");
    end else begin
      $display("[command_record_delta_encoder] ERROR");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5ms;
    $display("Timeout with %0d chunks still owed", predictor.expected_chunks.size());
    $display("[command_record_delta_encoder] ERROR");
    $finish;
  end

endmodule
